/* sv/priority_run_queue_scheduler_defines.svh */
// assertion macros for the run-queue scheduler
// uses aclk and aresetn of the including module
`ifndef PRIORITY_RUN_QUEUE_SCHEDULER_DEFINES_SVH
`define PRIORITY_RUN_QUEUE_SCHEDULER_DEFINES_SVH

// implication checked on every edge outside reset
`define PRQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("prq assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define PRQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("prq assertion failed");

`endif

/* sv/prq_pkg.sv */
// shared types and constants of the run-queue scheduler
// no dependencies
`default_nettype none

package prq_pkg;

    localparam int NUM_THREADS = 16;
    localparam int NUM_PRIOS   = 8;

    localparam int THR_W  = $clog2(NUM_THREADS);
    localparam int LNK_W  = $clog2(NUM_THREADS + 1);
    localparam int PRIO_W = $clog2(NUM_PRIOS);

    localparam logic [LNK_W-1:0] LNK_NIL = LNK_W'(NUM_THREADS);

    // command codes
    localparam logic [2:0] CMD_YIELD = 3'd0;
    localparam logic [2:0] CMD_BLOCK = 3'd1;
    localparam logic [2:0] CMD_WAKE  = 3'd2;
    localparam logic [2:0] CMD_SETP  = 3'd3;
    localparam logic [2:0] CMD_TICK  = 3'd4;

    // thread status codes
    localparam logic [1:0] TS_WAIT     = 2'd0;
    localparam logic [1:0] TS_RUNNABLE = 2'd1;
    localparam logic [1:0] TS_RUNNING  = 2'd2;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] thread_id;
        logic [2:0] new_prio;
    } in_item_t;

    typedef struct packed {
        logic [3:0] running_thread;
        logic       idle;
        logic       switched;
    } out_item_t;

    // one thread entry of the state memory
    typedef struct packed {
        logic [1:0]        status;
        logic [PRIO_W-1:0] prio;
        logic [LNK_W-1:0]  next;
        logic [LNK_W-1:0]  prev;
    } thr_word_t;

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE, ST_DEC, ST_YLD, ST_YLD1, ST_BLK1, ST_WAK1, ST_WAK2,
        ST_SP1, ST_SP2, ST_SP3, ST_SP4, ST_DSP, ST_DSP1, ST_ENQ0, ST_ENQ1,
        ST_UN0, ST_UN1, ST_UN2, ST_UN3, ST_FIN
    } seq_state_t;

    typedef struct packed {
        logic              we;
        logic [THR_W-1:0]  waddr;
        thr_word_t         wdata;
        logic [THR_W-1:0]  raddr;
    } mem_req_t;

endpackage

`default_nettype wire

/* sv/prq_tmem.sv */
// thread state memory: one write and one registered read per cycle
// depends on prq_pkg
`default_nettype none

module prq_tmem
    import prq_pkg::*;
(
    input  wire logic      aclk,
    input  wire mem_req_t  req,
    output thr_word_t      rdata
);

    thr_word_t mem [NUM_THREADS];

    // write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        rdata <= mem[req.raddr];
    end

endmodule

`default_nettype wire

/* sv/priority_run_queue_scheduler.sv */
// Each input transfer runs through read-modify-write steps on the thread memory
// (decode, then enqueue, unlink and dispatch as the command needs) before its result
// is loaded into the output register; a stalled result register holds the last step.
// Throughput: one event at a time; the next input is taken once the result has been
// loaded into the output register. Reset clears the thread memory in a pass over
// every entry during which no input is taken; thread 0 comes up running.
`default_nettype none
`include "priority_run_queue_scheduler_defines.svh"

module priority_run_queue_scheduler
    import prq_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    seq_state_t        state_reg, state_next, ret_reg, ret_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [THR_W-1:0]  tid_reg, tid_next;
    logic              tidok_reg, tidok_next;
    logic [PRIO_W-1:0] np_reg, np_next;
    thr_word_t         ent_reg, ent_next;
    logic [THR_W-1:0]  t_reg, t_next;
    logic [LNK_W-1:0]  aux_reg, aux_next;
    logic [THR_W-1:0]  cur_reg, cur_next;
    logic [PRIO_W-1:0] cur_prio_reg, cur_prio_next;
    logic              idle_reg, idle_next;
    logic              sw_reg, sw_next;
    logic [THR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;
    logic [LNK_W-1:0]  head_reg [NUM_PRIOS];
    logic [LNK_W-1:0]  tail_reg [NUM_PRIOS];

    logic              hd_we, tl_we;
    logic [PRIO_W-1:0] hd_idx, tl_idx;
    logic [LNK_W-1:0]  hd_val, tl_val;

    mem_req_t          mreq;
    thr_word_t         rdata;

    logic              found;
    logic [PRIO_W-1:0] best;
    thr_word_t         w;

    prq_tmem u_tmem (
        .aclk  (aclk),
        .req   (mreq),
        .rdata (rdata)
    );

    // highest non-empty queue
    always_comb begin
        found = 1'b0;
        best  = '0;
        for (int i = 0; i < NUM_PRIOS; i++) begin
            if (head_reg[i] != LNK_NIL) begin
                found = 1'b1;
                best  = PRIO_W'(i);
            end
        end
    end

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            ret_reg      <= ST_FIN;
            clr_cnt_reg  <= '0;
            cur_reg      <= '0;
            cur_prio_reg <= '0;
            idle_reg     <= 1'b0;
            sw_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            clr_cnt_reg  <= clr_cnt_next;
            cur_reg      <= cur_next;
            cur_prio_reg <= cur_prio_next;
            idle_reg     <= idle_next;
            sw_reg       <= sw_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // working payload registers
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        tid_reg    <= tid_next;
        tidok_reg  <= tidok_next;
        np_reg     <= np_next;
        ent_reg    <= ent_next;
        t_reg      <= t_next;
        aux_reg    <= aux_next;
        m_data_reg <= m_data_next;
    end

    // queue head and tail tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PRIOS; i++) begin
                head_reg[i] <= LNK_NIL;
                tail_reg[i] <= LNK_NIL;
            end
        end else begin
            if (hd_we) begin
                head_reg[hd_idx] <= hd_val;
            end
            if (tl_we) begin
                tail_reg[tl_idx] <= tl_val;
            end
        end
    end

    // next state and memory requests
    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        cmd_next      = cmd_reg;
        tid_next      = tid_reg;
        tidok_next    = tidok_reg;
        np_next       = np_reg;
        ent_next      = ent_reg;
        t_next        = t_reg;
        aux_next      = aux_reg;
        cur_next      = cur_reg;
        cur_prio_next = cur_prio_reg;
        idle_next     = idle_reg;
        sw_next       = sw_reg;
        clr_cnt_next  = clr_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        s_ready       = 1'b0;
        mreq          = '0;
        hd_we         = 1'b0;
        hd_idx        = ent_reg.prio;
        hd_val        = LNK_NIL;
        tl_we         = 1'b0;
        tl_idx        = ent_reg.prio;
        tl_val        = LNK_NIL;
        w             = ent_reg;

        unique case (state_reg)
            ST_CLR: begin
                mreq.we          = 1'b1;
                mreq.waddr       = clr_cnt_reg;
                mreq.wdata.status = (clr_cnt_reg == '0) ? TS_RUNNING : TS_WAIT;
                mreq.wdata.prio  = '0;
                mreq.wdata.next  = LNK_NIL;
                mreq.wdata.prev  = LNK_NIL;
                clr_cnt_next     = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == THR_W'(NUM_THREADS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next   = s_data.cmd;
                    tid_next   = THR_W'(s_data.thread_id);
                    tidok_next = 32'(s_data.thread_id) < NUM_THREADS;
                    np_next    = (32'(s_data.new_prio) >= NUM_PRIOS) ?
                                 PRIO_W'(NUM_PRIOS - 1) : PRIO_W'(s_data.new_prio);
                    sw_next    = 1'b0;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                mreq.raddr = tid_reg;
                unique case (cmd_reg) inside
                    CMD_YIELD, CMD_TICK: state_next = ST_YLD;
                    CMD_BLOCK: begin
                        mreq.raddr = cur_reg;
                        state_next = idle_reg ? ST_DSP : ST_BLK1;
                    end
                    CMD_WAKE:  state_next = tidok_reg ? ST_WAK1 : ST_FIN;
                    CMD_SETP:  state_next = tidok_reg ? ST_SP1 : ST_FIN;
                    default:   state_next = ST_FIN;
                endcase
            end
            // running thread back to its queue, then dispatch
            ST_YLD: begin
                mreq.raddr = cur_reg;
                t_next     = cur_reg;
                state_next = idle_reg ? ST_DSP : ST_YLD1;
            end
            ST_YLD1: begin
                ent_next        = rdata;
                ent_next.status = TS_RUNNABLE;
                ret_next        = ST_DSP;
                state_next      = ST_ENQ0;
            end
            ST_BLK1: begin
                mreq.we           = 1'b1;
                mreq.waddr        = cur_reg;
                mreq.wdata        = rdata;
                mreq.wdata.status = TS_WAIT;
                state_next        = ST_DSP;
            end
            ST_WAK1: begin
                if (rdata.status == TS_WAIT) begin
                    ent_next        = rdata;
                    ent_next.status = TS_RUNNABLE;
                    t_next          = tid_reg;
                    ret_next        = ST_WAK2;
                    state_next      = ST_ENQ0;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_WAK2: begin
                if (idle_reg) begin
                    state_next = ST_DSP;
                end else if (ent_reg.prio > cur_prio_reg) begin
                    state_next = ST_YLD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            // set priority
            ST_SP1: begin
                ent_next = rdata;
                t_next   = tid_reg;
                if (tid_reg == cur_reg) begin
                    cur_prio_next = np_reg;
                end
                state_next = ST_SP2;
            end
            ST_SP2: begin
                if (ent_reg.status == TS_RUNNABLE) begin
                    ret_next   = ST_SP3;
                    state_next = ST_UN0;
                end else begin
                    mreq.we         = 1'b1;
                    mreq.waddr      = t_reg;
                    mreq.wdata      = ent_reg;
                    mreq.wdata.prio = np_reg;
                    state_next      = ST_SP4;
                end
            end
            ST_SP3: begin
                ent_next.prio = np_reg;
                ret_next      = ST_SP4;
                state_next    = ST_ENQ0;
            end
            ST_SP4: begin
                state_next = (!idle_reg && np_reg > cur_prio_reg) ? ST_YLD : ST_FIN;
            end
            // dispatch the head of the highest non-empty queue
            ST_DSP: begin
                if (found) begin
                    mreq.raddr = head_reg[best][THR_W-1:0];
                    cur_next   = head_reg[best][THR_W-1:0];
                    sw_next    = 1'b1;
                    idle_next  = 1'b0;
                    state_next = ST_DSP1;
                end else begin
                    idle_next  = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_DSP1: begin
                ent_next        = rdata;
                ent_next.status = TS_RUNNING;
                cur_prio_next   = rdata.prio;
                t_next          = cur_reg;
                ret_next        = ST_FIN;
                state_next      = ST_UN0;
            end
            // enqueue t_reg at the tail of its queue
            ST_ENQ0: begin
                w.next      = LNK_NIL;
                w.prev      = tail_reg[ent_reg.prio];
                mreq.we     = 1'b1;
                mreq.waddr  = t_reg;
                mreq.wdata  = w;
                tl_we       = 1'b1;
                tl_val      = LNK_W'(t_reg);
                aux_next    = tail_reg[ent_reg.prio];
                mreq.raddr  = tail_reg[ent_reg.prio][THR_W-1:0];
                if (tail_reg[ent_reg.prio] == LNK_NIL) begin
                    hd_we      = 1'b1;
                    hd_val     = LNK_W'(t_reg);
                    state_next = ret_reg;
                end else begin
                    state_next = ST_ENQ1;
                end
            end
            ST_ENQ1: begin
                mreq.we         = 1'b1;
                mreq.waddr      = aux_reg[THR_W-1:0];
                mreq.wdata      = rdata;
                mreq.wdata.next = LNK_W'(t_reg);
                state_next      = ret_reg;
            end
            // unlink t_reg from its queue
            ST_UN0: begin
                w.next     = LNK_NIL;
                w.prev     = LNK_NIL;
                mreq.we    = 1'b1;
                mreq.waddr = t_reg;
                mreq.wdata = w;
                mreq.raddr = ent_reg.prev[THR_W-1:0];
                if (ent_reg.prev != LNK_NIL) begin
                    state_next = ST_UN1;
                end else begin
                    hd_we      = 1'b1;
                    hd_val     = ent_reg.next;
                    state_next = ST_UN2;
                end
            end
            ST_UN1: begin
                mreq.we         = 1'b1;
                mreq.waddr      = ent_reg.prev[THR_W-1:0];
                mreq.wdata      = rdata;
                mreq.wdata.next = ent_reg.next;
                state_next      = ST_UN2;
            end
            ST_UN2: begin
                mreq.raddr = ent_reg.next[THR_W-1:0];
                if (ent_reg.next != LNK_NIL) begin
                    state_next = ST_UN3;
                end else begin
                    tl_we      = 1'b1;
                    tl_val     = ent_reg.prev;
                    state_next = ret_reg;
                end
            end
            ST_UN3: begin
                mreq.we         = 1'b1;
                mreq.waddr      = ent_reg.next[THR_W-1:0];
                mreq.wdata      = rdata;
                mreq.wdata.prev = ent_reg.prev;
                state_next      = ret_reg;
            end
            // result into the output register
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.running_thread = idle_reg ? 4'd0 : 4'(cur_reg);
                    m_data_next.idle           = idle_reg;
                    m_data_next.switched       = sw_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PRQ_ASSERT_IMP(a_idle_zero, m_valid && m_data.idle, m_data.running_thread == 4'd0)
    `PRQ_ASSERT_IMP(a_sw_not_idle, m_valid && m_data.switched, !m_data.idle)
    `PRQ_ASSERT_IMP(a_no_wr_idle, state_reg == ST_IDLE, !mreq.we)
    `PRQ_ASSERT_NXT(a_fin_loads, state_reg == ST_FIN && state_next == ST_IDLE, m_valid)

endmodule

`default_nettype wire

/* tb/sv/prq_event_checker.sv */
// checker for the run-queue scheduler: watches both channels, predicts each result
// depends on prq_pkg
`default_nettype none

module prq_event_checker
    import prq_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire in_item_t  s_data,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_item_t m_data,
    output int             fail_count,
    output int             pending_count
);

    localparam int NIL = NUM_THREADS;

    logic [1:0] status_q [NUM_THREADS];
    int         prio_q [NUM_THREADS];
    int         next_q [NUM_THREADS];
    int         prev_q [NUM_THREADS];
    int         head_q [NUM_PRIOS];
    int         tail_q [NUM_PRIOS];
    int         run_thread;
    bit         is_idle;
    out_item_t  sched_results [$];

    function automatic void link_tail(int t);
        int p;
        p = prio_q[t];
        prev_q[t] = tail_q[p];
        next_q[t] = NIL;
        if (tail_q[p] == NIL) head_q[p] = t;
        else next_q[tail_q[p]] = t;
        tail_q[p] = t;
    endfunction

    function automatic void unlink(int t);
        int p;
        p = prio_q[t];
        if (prev_q[t] == NIL) head_q[p] = next_q[t];
        else next_q[prev_q[t]] = next_q[t];
        if (next_q[t] == NIL) tail_q[p] = prev_q[t];
        else prev_q[next_q[t]] = prev_q[t];
        next_q[t] = NIL;
        prev_q[t] = NIL;
    endfunction

    function automatic bit pick_next();
        int h;
        for (int i = NUM_PRIOS - 1; i >= 0; i--) begin
            h = head_q[i];
            if (h != NIL) begin
                unlink(h);
                status_q[h] = TS_RUNNING;
                run_thread = h;
                is_idle = 0;
                return 1;
            end
        end
        is_idle = 1;
        return 0;
    endfunction

    function automatic bit requeue_current();
        if (!is_idle) begin
            status_q[run_thread] = TS_RUNNABLE;
            link_tail(run_thread);
        end
        return pick_next();
    endfunction

    function automatic void reset_sched();
        for (int i = 0; i < NUM_THREADS; i++) begin
            status_q[i] = TS_WAIT;
            prio_q[i] = 0;
            next_q[i] = NIL;
            prev_q[i] = NIL;
        end
        for (int i = 0; i < NUM_PRIOS; i++) begin
            head_q[i] = NIL;
            tail_q[i] = NIL;
        end
        status_q[0] = TS_RUNNING;
        run_thread = 0;
        is_idle = 0;
    endfunction

    function automatic out_item_t schedule_event(in_item_t ev);
        out_item_t r;
        bit sw;
        int tid;
        int np;
        sw = 0;
        tid = ev.thread_id;
        np = (ev.new_prio > NUM_PRIOS - 1) ? NUM_PRIOS - 1 : ev.new_prio;
        case (ev.cmd) inside
            CMD_YIELD, CMD_TICK: begin
                sw = requeue_current();
            end
            CMD_BLOCK: begin
                if (!is_idle) status_q[run_thread] = TS_WAIT;
                sw = pick_next();
            end
            CMD_WAKE: begin
                if (tid < NUM_THREADS && status_q[tid] == TS_WAIT) begin
                    status_q[tid] = TS_RUNNABLE;
                    link_tail(tid);
                    if (is_idle) sw = pick_next();
                    else if (prio_q[tid] > prio_q[run_thread]) sw = requeue_current();
                end
            end
            CMD_SETP: begin
                if (tid < NUM_THREADS) begin
                    if (status_q[tid] == TS_RUNNABLE) begin
                        unlink(tid);
                        prio_q[tid] = np;
                        link_tail(tid);
                    end else begin
                        prio_q[tid] = np;
                    end
                    if (!is_idle && np > prio_q[run_thread]) sw = requeue_current();
                end
            end
            default: ;
        endcase
        r.running_thread = is_idle ? 4'd0 : 4'(run_thread);
        r.idle = is_idle;
        r.switched = sw;
        return r;
    endfunction

    // predict on input transfer, compare on result transfer
    always @(posedge aclk) begin
        out_item_t exp_r;
        int        errs;
        errs = 0;
        if (!aresetn) begin
            reset_sched();
            sched_results.delete();
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) sched_results.push_back(schedule_event(s_data));
            if (m_valid && m_ready) begin
                if (sched_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errs++;
                end else begin
                    exp_r = sched_results.pop_front();
                    if (m_data.running_thread !== exp_r.running_thread) begin
                        $error("running_thread: expected %0d, got %0d",
                               exp_r.running_thread, m_data.running_thread);
                        errs++;
                    end
                    if (m_data.idle !== exp_r.idle) begin
                        $error("idle: expected %0d, got %0d", exp_r.idle, m_data.idle);
                        errs++;
                    end
                    if (m_data.switched !== exp_r.switched) begin
                        $error("switched: expected %0d, got %0d",
                               exp_r.switched, m_data.switched);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
        pending_count <= sched_results.size();
    end

endmodule

`default_nettype wire

/* tb/sv/priority_run_queue_scheduler_tb.sv */
// top of the run-queue scheduler testbench: clock, reset, stimulus and verdict
// depends on prq_pkg, priority_run_queue_scheduler and prq_event_checker
`default_nettype none

module priority_run_queue_scheduler_tb;
    import prq_pkg::*;

    logic      aclk = 0;
    logic      aresetn = 0;
    logic      s_valid = 0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 0;
    out_item_t m_data;
    int        fail_count;
    int        pending_count;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    always #2 aclk = ~aclk;

    priority_run_queue_scheduler u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    prq_event_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // receiver stalls at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one event transfer with optional idle cycles ahead of it
    task automatic send_event(logic [2:0] cmd, logic [3:0] tid, logic [2:0] np);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= '{cmd: cmd, thread_id: tid, new_prio: np};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // a random mix of wakes, yields, ticks, blocks and priority sets over all threads, some noise
    task automatic random_events(int count);
        int r;
        logic [2:0] cmd;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 30) cmd = CMD_WAKE;
            else if (r < 45) cmd = CMD_YIELD;
            else if (r < 55) cmd = CMD_TICK;
            else if (r < 72) cmd = CMD_BLOCK;
            else if (r < 94) cmd = CMD_SETP;
            else cmd = 3'($urandom_range(7));
            send_event(cmd, 4'($urandom_range(15)), 3'($urandom_range(7)));
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        // directed: idle entry, wake from idle, preemption, requeue, unknown codes
        send_event(CMD_BLOCK, 4'd0, 3'd0);
        send_event(CMD_YIELD, 4'd0, 3'd0);
        send_event(CMD_TICK, 4'd0, 3'd0);
        send_event(CMD_BLOCK, 4'd0, 3'd0);
        send_event(CMD_WAKE, 4'd15, 3'd0);
        send_event(CMD_WAKE, 4'd3, 3'd0);
        send_event(CMD_SETP, 4'd3, 3'd7);
        send_event(CMD_WAKE, 4'd15, 3'd0);
        send_event(CMD_SETP, 4'd15, 3'd7);
        send_event(CMD_YIELD, 4'd0, 3'd0);
        send_event(CMD_WAKE, 4'd5, 3'd0);
        send_event(CMD_SETP, 4'd5, 3'd2);
        send_event(CMD_SETP, 4'd5, 3'd1);
        send_event(CMD_SETP, 4'd0, 3'd5);
        send_event(CMD_WAKE, 4'd0, 3'd0);
        send_event(CMD_WAKE, 4'd0, 3'd0);
        send_event(CMD_TICK, 4'd0, 3'd0);
        send_event(3'd5, 4'd1, 3'd1);
        send_event(3'd6, 4'd2, 3'd2);
        send_event(3'd7, 4'd15, 3'd7);
        send_event(CMD_BLOCK, 4'd0, 3'd0);
        send_event(CMD_BLOCK, 4'd0, 3'd0);
        send_event(CMD_BLOCK, 4'd0, 3'd0);
        send_event(CMD_BLOCK, 4'd0, 3'd0);
        drain_results();
        // random phases with different idling
        random_events(300);
        send_idle_pct = 61;
        random_events(250);
        drain_results();
        send_idle_pct = 0;
        recv_stall_pct = 61;
        random_events(250);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        random_events(250);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_events(250);
        drain_results();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // overall run limit
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
